[hw/rtl/rms_level_meter_top_defines.svh]
// ----------------------------------------------------------------------------
// rms_level_meter_top_defines.svh
// Assertion macros shared by the RMS level meter RTL.
// ----------------------------------------------------------------------------
`ifndef RMS_LEVEL_METER_TOP_DEFINES_SVH
`define RMS_LEVEL_METER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// ante true -> cons true in the same cycle
`define RLM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante true -> cons true in the next cycle
`define RLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLM_ASSERT_SAME(lbl, ante, cons, msg)
`define RLM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/rlm_pkg.sv]
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;  // default buffer limit
  localparam int SAMPLE_W        = 16;
  localparam int SQ_W            = 31;    // (-32768)^2 = 2^30 needs 31 bits
  localparam int LEVEL_W         = 17;
  localparam int USED_W          = 13;
  localparam int Q_W             = 33;    // 4 * mean square <= 2^32
  localparam int ROOT_W          = Q_W + 1;
  localparam int SQRT_STEPS      = (Q_W + 1) / 2;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);

  typedef struct packed {
    logic capture;    // latch incoming request
    logic square;     // register sample * sample
    logic accum;      // add square to running sum, bump count; flag drop when full
    logic div_init;   // load divider
    logic div_step;   // one restoring divide step
    logic root_init;  // load square root unit
    logic root_step;  // one square root step
    logic emit;       // load output register, clear accumulators
  } rlm_cmd_t;

  typedef struct packed {
    logic last_flag;  // captured request ends the buffer
    logic out_free;   // output register can take a result this cycle
  } rlm_stat_t;

endpackage

[hw/rtl/rlm_ctrl.sv]
// ----------------------------------------------------------------------------
// rlm_ctrl
// Sequencer: accumulate per sample, then divide and root at buffer end.
// ----------------------------------------------------------------------------
module rlm_ctrl
  import rlm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_stall,
  input  rlm_stat_t stat,
  output rlm_cmd_t  cmd
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int DVD_W  = SUM_W + 2;
  localparam int STEP_W = $clog2(DVD_W);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_SQUARE    = 8'b00000010,
    S_ACCUM     = 8'b00000100,
    S_DIV_INIT  = 8'b00001000,
    S_DIV       = 8'b00010000,
    S_ROOT_INIT = 8'b00100000,
    S_ROOT      = 8'b01000000,
    S_EMIT      = 8'b10000000
  } state_t;

  state_t              state, state_next;
  logic   [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = stat.last_flag ? S_DIV_INIT : S_IDLE;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = STEP_W'(DVD_W - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '0) begin
          state_next = S_ROOT_INIT;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        step_next     = STEP_W'(SQRT_STEPS - 1);
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (step == '0) begin
          state_next = S_EMIT;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign sample_stall = (state != S_IDLE);

endmodule

[hw/rtl/rlm_datapath.sv]
// ----------------------------------------------------------------------------
// rlm_datapath
// Square/accumulate, restoring divider, bitwise square root, output register.
// ----------------------------------------------------------------------------
`include "rms_level_meter_top_defines.svh"

module rlm_datapath
  import rlm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rlm_cmd_t                   cmd,
  output rlm_stat_t                  stat,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       level_valid,
  input  logic                       level_stall,
  output logic        [LEVEL_W-1:0]  level,
  output logic        [USED_W-1:0]   samples_used,
  output logic                       truncated
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SQ_W - 1 + CNT_W;
  localparam int DVD_W = SUM_W + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // request capture and squaring
  logic signed [SAMPLE_W-1:0]   sample_r;
  logic                         last_r;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic        [SQ_W-1:0]       sq;

  // accumulators
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] tally;
  logic             overflowed;

  // divider
  logic [DVD_W-1:0] dvd;
  logic [CNT_W-1:0] rem;
  logic [Q_W-1:0]   quo;
  logic [CNT_W:0]   trial;
  logic             qbit;

  // square root
  logic [Q_W-1:0]    rad;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] rbit;
  logic [ROOT_W-1:0] rtrial;
  logic              rfit;

  logic [LEVEL_W-1:0]      level_calc;
  logic [USED_W+CNT_W-1:0] used_ext;

  assign prod = sample_r * sample_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
      last_r   <= last;
    end
    if (cmd.square) begin
      sq <= prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      tally      <= '0;
      overflowed <= 1'b0;
    end else if (cmd.emit) begin
      sum        <= '0;
      tally      <= '0;
      overflowed <= 1'b0;
    end else if (cmd.accum) begin
      if (tally < CNT_MAX) begin
        sum   <= sum + SUM_W'(sq);
        tally <= tally + 1'b1;
      end else begin
        overflowed <= 1'b1;
      end
    end
  end

  // restoring divide of 4*sum by tally, one quotient bit per cycle; the
  // quotient is known to fit Q_W bits so the upper bits shift out as zero
  assign trial = {rem, dvd[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, tally});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd <= {sum, 2'b00};
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= qbit ? CNT_W'(trial - {1'b0, tally}) : trial[CNT_W-1:0];
      quo <= {quo[Q_W-2:0], qbit};
    end
  end

  // digit-by-digit integer square root, two radicand bits per cycle
  assign rtrial = root + rbit;
  assign rfit   = ({1'b0, rad} >= rtrial);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= quo;
      root <= '0;
      rbit <= ROOT_W'(1) << (Q_W - 1);
    end else if (cmd.root_step) begin
      if (rfit) begin
        rad  <= Q_W'({1'b0, rad} - rtrial);
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_comb begin
    if (tally == '0) begin
      level_calc = '0;
    end else if (root > ROOT_W'(FULL_SCALE)) begin
      level_calc = FULL_SCALE;
    end else begin
      level_calc = root[LEVEL_W-1:0];
    end
  end

  assign used_ext = {{USED_W{1'b0}}, tally};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (cmd.emit) begin
      level_valid <= 1'b1;
    end else if (!level_stall) begin
      level_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level        <= level_calc;
      samples_used <= used_ext[USED_W-1:0];
      truncated    <= overflowed;
    end
  end

  assign stat.last_flag = last_r;
  assign stat.out_free  = !level_valid || !level_stall;

  `RLM_ASSERT_SAME(a_tally_bound, 1'b1, tally <= CNT_MAX, "sample count above limit")
  `RLM_ASSERT_SAME(a_ovf_full, overflowed, tally == CNT_MAX, "drop flagged on open buffer")
  `RLM_ASSERT_NEXT(a_emit_clear, cmd.emit, tally == '0 && !overflowed && sum == '0,
                   "accumulators not cleared after result")
  `RLM_ASSERT_SAME(a_level_range, level_valid, level <= FULL_SCALE, "level above full scale")

endmodule

[hw/rtl/rms_level_meter_top.sv]
// ----------------------------------------------------------------------------
// rms_level_meter_top
// RMS level of buffers of signed 16-bit audio samples, unsigned Q16 result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (sample_valid / sample_stall) carries one request per
//   audio sample plus a last flag that closes the buffer. Output channel
//   (level_valid / level_stall) carries one result per buffer: level,
//   samples_used and truncated. Nothing is emitted for samples without last.
//   Sequence: a sample without last occupies the block through accept,
//   square and accumulate. A sample with last then runs divider load,
//   one divider bit per cycle over the widened sum of DVD_W = 32 +
//   clog2(MAX_SAMPLES + 1) bits in the restoring divider, root load and
//   17 root steps in the root unit, until the result is loaded.
//   A waiting result sits in the output register while the next buffer is
//   accumulated; only a second result waits for that register to drain.
//   Reset (rst, synchronous) clears the sum, count, drop flag and output
//   valid. While level_stall is high the result holds steady.
//   Samples past MAX_SAMPLES in one buffer are dropped and flag truncated.
// ----------------------------------------------------------------------------
module rms_level_meter_top
  import rlm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       level_valid,
  input  logic                       level_stall,
  output logic        [LEVEL_W-1:0]  level,
  output logic        [USED_W-1:0]   samples_used,
  output logic                       truncated
);

  rlm_cmd_t  cmd;   // controller -> datapath
  rlm_stat_t stat;  // datapath -> controller

  rlm_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  rlm_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .last         (last),
    .level_valid  (level_valid),
    .level_stall  (level_stall),
    .level        (level),
    .samples_used (samples_used),
    .truncated    (truncated)
  );

endmodule
